FILE: sv/mrd_pkg.sv
// Shared types, constants and the CRC step function for the meter reply deframer.
package mrd_pkg;

  // Frame layout of the meter reply.
  localparam int unsigned ReplyLength  = 25;
  localparam int unsigned PayloadFirst = 3;
  localparam int unsigned PayloadDepth = ReplyLength - PayloadFirst - 2;
  localparam int unsigned CrcLowPos    = ReplyLength - 2;
  localparam int unsigned CrcHighPos   = ReplyLength - 1;
  localparam int unsigned CountW       = $clog2(ReplyLength + 1);
  localparam int unsigned PayloadIdxW  = $clog2(PayloadDepth);

  // CRC-16/MODBUS: reflected polynomial, all-ones start, no final xor.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Reset value of the comms alarm code register.
  localparam logic [15:0] CommsAlarmReset = 16'd206;

  // Item commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  // One input item.
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] voltage_raw;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] frequency_raw;
    logic [15:0] power_factor_raw;
    logic [15:0] alarm_word;
  } result_t;

  // One byte of CRC-16/MODBUS, eight bit steps on a 16-bit value.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/mrd_in_stage.sv
// Input register stage: holds one accepted item until the frame engine takes it.
module mrd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mrd_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output mrd_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  mrd_pkg::item_t item_q;
  logic           load;

  // The register frees up in the same cycle that the engine takes its item.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/mrd_frame_engine.sv
// Frame engine: byte counting, CRC, payload capture and result formation.
module mrd_frame_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mrd_pkg::item_t   item_i,
  input  logic             out_ready_i,
  input  logic [15:0]      comms_alarm_i,
  output logic             advance_o,
  output logic             res_valid_o,
  output mrd_pkg::result_t result_o
);

  logic [mrd_pkg::CountW-1:0]      count_q, count_d;
  logic [15:0]                     crc_q, crc_d;
  logic [7:0]                      crc_low_q, crc_low_d;
  logic                            match_q, match_d;
  logic [7:0]                      payload_q [mrd_pkg::PayloadDepth];
  logic                            is_eof;
  logic                            byte_fire;
  logic                            pay_we;
  logic [mrd_pkg::CountW-1:0]      pay_off;
  logic [mrd_pkg::PayloadIdxW-1:0] pay_idx;
  logic                            frame_ok;

  // A byte item never waits; an end-of-frame item waits for the output register.
  assign is_eof      = (item_i.cmd == mrd_pkg::CMD_EOF);
  assign advance_o   = valid_i && (!is_eof || out_ready_i);
  assign res_valid_o = advance_o && is_eof;
  assign byte_fire   = advance_o && !is_eof &&
                       (count_q < mrd_pkg::CountW'(mrd_pkg::ReplyLength));

  // Payload slot for the current byte.
  assign pay_off = count_q - mrd_pkg::CountW'(mrd_pkg::PayloadFirst);
  assign pay_idx = pay_off[mrd_pkg::PayloadIdxW-1:0];
  assign pay_we  = byte_fire &&
                   (count_q >= mrd_pkg::CountW'(mrd_pkg::PayloadFirst)) &&
                   (count_q <  mrd_pkg::CountW'(mrd_pkg::CrcLowPos));

  // Next frame state.
  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    match_d   = match_q;
    if (res_valid_o) begin
      count_d   = '0;
      crc_d     = mrd_pkg::CrcInit;
      crc_low_d = '0;
      match_d   = 1'b0;
    end else if (byte_fire) begin
      if (count_q < mrd_pkg::CountW'(mrd_pkg::CrcLowPos)) begin
        crc_d = mrd_pkg::crc_update(crc_q, item_i.rx_byte);
      end
      if (count_q == mrd_pkg::CountW'(mrd_pkg::CrcLowPos)) begin
        crc_low_d = item_i.rx_byte;
      end
      if (count_q == mrd_pkg::CountW'(mrd_pkg::CrcHighPos)) begin
        match_d = ({item_i.rx_byte, crc_low_q} == crc_q);
      end
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= mrd_pkg::CrcInit;
      crc_low_q <= '0;
      match_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
      match_q   <= match_d;
    end
  end

  // Payload bytes, kept across frames.
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[pay_idx] <= item_i.rx_byte;
    end
  end

  // Result fields; 32-bit values arrive low word first, each word big-endian.
  assign frame_ok = (count_q == mrd_pkg::CountW'(mrd_pkg::ReplyLength)) && match_q;

  always_comb begin
    result_o = '0;
    if (frame_ok) begin
      result_o.frame_ok         = 1'b1;
      result_o.voltage_raw      = {payload_q[0], payload_q[1]};
      result_o.current_raw      = {payload_q[4], payload_q[5], payload_q[2], payload_q[3]};
      result_o.power_raw        = {payload_q[8], payload_q[9], payload_q[6], payload_q[7]};
      result_o.energy_raw       = {payload_q[12], payload_q[13],
                                   payload_q[10], payload_q[11]};
      result_o.frequency_raw    = {payload_q[14], payload_q[15]};
      result_o.power_factor_raw = {payload_q[16], payload_q[17]};
      result_o.alarm_word       = {payload_q[18], payload_q[19]};
    end else begin
      result_o.alarm_word = comms_alarm_i;
    end
  end

endmodule

FILE: sv/mrd_out_stage.sv
// Output register stage: holds one result item until downstream takes it.
module mrd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mrd_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mrd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  mrd_pkg::result_t result_q;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: sv/meter_reply_deframer_crc_core.sv
// Top level of the meter reply deframer with CRC-16/MODBUS check.
//
// Takes the bytes of a 25-byte meter reply one item per clock, save while the
// input stalls, and, on an end-of-frame item, delivers one result item with the
// raw measurement fields when exactly 25 bytes arrived (extra bytes are ignored)
// and the CRC over the first 23 bytes matches, or otherwise the comms alarm code
// with zero values. A new item is accepted whenever the input does not stall; an
// item is held in the input register and is worked in a single pass from there
// into the output register, which holds the result until it is taken. Input
// stall rises only while an end-of-frame item waits for a stalled output
// register. The alarm code register is written through its own port, which is
// always ready.
module meter_reply_deframer_crc_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [15:0] voltage_raw_o,
  output logic [31:0] current_raw_o,
  output logic [31:0] power_raw_o,
  output logic [31:0] energy_raw_o,
  output logic [15:0] frequency_raw_o,
  output logic [15:0] power_factor_raw_o,
  output logic [15:0] alarm_word_o
);

  logic [15:0]      alarm_code_q;
  mrd_pkg::item_t   in_item;
  mrd_pkg::item_t   eng_item;
  logic             eng_valid;
  logic             advance;
  logic             res_valid;
  logic             out_ready;
  mrd_pkg::result_t eng_result;
  mrd_pkg::result_t out_result;

  // Comms alarm code register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_code_q <= mrd_pkg::CommsAlarmReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alarm_code_q <= cfg_data_i;
    end
  end

  assign in_item.cmd     = cmd_i;
  assign in_item.rx_byte = rx_byte_i;

  mrd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (eng_valid),
    .item_o     (eng_item)
  );

  mrd_frame_engine u_frame_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (eng_valid),
    .item_i        (eng_item),
    .out_ready_i   (out_ready),
    .comms_alarm_i (alarm_code_q),
    .advance_o     (advance),
    .res_valid_o   (res_valid),
    .result_o      (eng_result)
  );

  mrd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .result_i    (eng_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  // Result fields onto their ports.
  assign frame_ok_o         = out_result.frame_ok;
  assign voltage_raw_o      = out_result.voltage_raw;
  assign current_raw_o      = out_result.current_raw;
  assign power_raw_o        = out_result.power_raw;
  assign energy_raw_o       = out_result.energy_raw;
  assign frequency_raw_o    = out_result.frequency_raw;
  assign power_factor_raw_o = out_result.power_factor_raw;
  assign alarm_word_o       = out_result.alarm_word;

endmodule

FILE: test/meter_reply_checker.sv
// Checker for the meter reply deframer: predicts each reply and compares it with the block's output.
`timescale 1ns / 1ps

module meter_reply_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             cmd_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  mrd_pkg::result_t reply_i,
  output int               err_count_o,
  output int               pending_o
);

  // Predicted frame state and the alarm code register.
  logic [mrd_pkg::CountW-1:0] rx_count;
  logic [15:0]                crc_acc;
  logic [7:0]                 body_bytes [mrd_pkg::PayloadDepth];
  logic [7:0]                 crc_lo;
  logic                       crc_ok;
  logic [15:0]                alarm_code;

  mrd_pkg::result_t expected_replies [$];
  int               errors = 0;
  int               pending = 0;

  assign err_count_o = errors;
  assign pending_o   = pending;

  // Big-endian 16-bit word starting at a byte position of the reply.
  function automatic logic [15:0] word_at(input int unsigned pos);
    return {body_bytes[pos - mrd_pkg::PayloadFirst],
            body_bytes[pos - mrd_pkg::PayloadFirst + 1]};
  endfunction

  // Back to the start of a frame; the stored payload bytes are kept.
  task automatic restart_frame();
    rx_count = '0;
    crc_acc  = mrd_pkg::CrcInit;
    crc_lo   = 8'h00;
    crc_ok   = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: reply mismatch, %s", $time, what);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [15:0]      c;
    mrd_pkg::result_t want;
    int               k;
    if (!rst_ni) begin
      alarm_code = mrd_pkg::CommsAlarmReset;
      restart_frame();
      for (k = 0; k < mrd_pkg::PayloadDepth; k++) begin
        body_bytes[k] = 8'h00;
      end
      expected_replies.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        alarm_code = cfg_data_i;
      end

      // A result item is matched against the oldest outstanding reply.
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply delivered with none outstanding");
        end else begin
          want = expected_replies.pop_front();
          compare_field("frame_ok", 32'(reply_i.frame_ok), 32'(want.frame_ok));
          compare_field("voltage_raw", 32'(reply_i.voltage_raw), 32'(want.voltage_raw));
          compare_field("current_raw", reply_i.current_raw, want.current_raw);
          compare_field("power_raw", reply_i.power_raw, want.power_raw);
          compare_field("energy_raw", reply_i.energy_raw, want.energy_raw);
          compare_field("frequency_raw", 32'(reply_i.frequency_raw),
                        32'(want.frequency_raw));
          compare_field("power_factor_raw", 32'(reply_i.power_factor_raw),
                        32'(want.power_factor_raw));
          compare_field("alarm_word", 32'(reply_i.alarm_word), 32'(want.alarm_word));
        end
      end

      // An accepted input item advances the frame or closes it.
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == mrd_pkg::CMD_BYTE) begin
          // Bytes beyond the reply length are dropped.
          if (rx_count < mrd_pkg::ReplyLength) begin
            if (rx_count < mrd_pkg::CrcLowPos) begin
              c = crc_acc ^ {8'h00, rx_byte_i};
              for (k = 0; k < 8; k++) begin
                c = (c >> 1) ^ (c[0] ? mrd_pkg::CrcPoly : 16'h0000);
              end
              crc_acc = c;
            end
            if (rx_count >= mrd_pkg::PayloadFirst &&
                rx_count < mrd_pkg::PayloadFirst + mrd_pkg::PayloadDepth) begin
              body_bytes[rx_count - mrd_pkg::PayloadFirst] = rx_byte_i;
            end
            if (rx_count == mrd_pkg::CrcLowPos) begin
              crc_lo = rx_byte_i;
            end
            if (rx_count == mrd_pkg::CrcHighPos) begin
              crc_ok = ({rx_byte_i, crc_lo} == crc_acc);
            end
            rx_count = rx_count + 1'b1;
          end
        end else begin
          // End of frame: full and intact replies carry the measurements, all
          // others only the comms alarm code.
          want = '0;
          if (rx_count == mrd_pkg::ReplyLength && crc_ok) begin
            want.frame_ok         = 1'b1;
            want.voltage_raw      = word_at(3);
            want.current_raw      = {word_at(7), word_at(5)};
            want.power_raw        = {word_at(11), word_at(9)};
            want.energy_raw       = {word_at(15), word_at(13)};
            want.frequency_raw    = word_at(17);
            want.power_factor_raw = word_at(19);
            want.alarm_word       = word_at(21);
          end else begin
            want.alarm_word = alarm_code;
          end
          expected_replies.push_back(want);
          restart_frame();
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the meter reply deframer: drives frames, idles both sides and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

  // Several times the longest held-off receiver stretch.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 400;

  typedef enum int {
    FRAME_GOOD,
    FRAME_EXTRA,
    FRAME_BAD_CRC,
    FRAME_SHORT,
    FRAME_NOISE
  } frame_kind_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [15:0]      cfg_data = 16'h0000;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             cmd = mrd_pkg::CMD_BYTE;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mrd_pkg::result_t dut_reply;
  int               chk_errors;
  int               chk_pending;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int items_sent = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  always #2 clk = ~clk;

  meter_reply_deframer_crc_core u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cmd_i              (cmd),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .frame_ok_o         (dut_reply.frame_ok),
    .voltage_raw_o      (dut_reply.voltage_raw),
    .current_raw_o      (dut_reply.current_raw),
    .power_raw_o        (dut_reply.power_raw),
    .energy_raw_o       (dut_reply.energy_raw),
    .frequency_raw_o    (dut_reply.frequency_raw),
    .power_factor_raw_o (dut_reply.power_factor_raw),
    .alarm_word_o       (dut_reply.alarm_word)
  );

  meter_reply_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cmd_i       (cmd),
    .rx_byte_i   (rx_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .reply_i     (dut_reply),
    .err_count_o (chk_errors),
    .pending_o   (chk_pending)
  );

  // Result side: random stalls, or a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offers one item, with random gaps before it, and returns at the falling
  // edge after it was taken. Valid is left high for the next caller.
  task automatic send_item(input logic c, input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops offering items until every reply is back, then lets the block settle.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_alarm_code(input logic [15:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Builds a reply with a correct CRC, then damages, trims or extends it by kind; noise sends random items.
  task automatic send_frame(input frame_kind_e kind, input bit flat);
    logic [7:0]  fr [mrd_pkg::ReplyLength];
    logic [15:0] crc;
    int          len;
    int          i;
    int          n;
    if (kind == FRAME_NOISE) begin
      n = $urandom_range(1, 30);
      repeat (n) send_item(($urandom_range(7) == 0) ? mrd_pkg::CMD_EOF : mrd_pkg::CMD_BYTE,
                           8'($urandom_range(255)));
      send_item(mrd_pkg::CMD_EOF, 8'($urandom_range(255)));
      items_sent += n + 1;
    end else begin
      fr[0] = 8'($urandom_range(255));
      fr[1] = 8'h04;
      fr[2] = 8'h14;
      for (i = mrd_pkg::PayloadFirst; i < mrd_pkg::CrcLowPos; i++) begin
        case ($urandom_range(15))
          0:       fr[i] = 8'h00;
          1:       fr[i] = 8'hFF;
          default: fr[i] = 8'($urandom_range(255));
        endcase
        if (flat) fr[i] = 8'hFF;
      end
      crc = mrd_pkg::CrcInit;
      for (i = 0; i < mrd_pkg::CrcLowPos; i++) begin
        crc = mrd_pkg::crc_update(crc, fr[i]);
      end
      fr[mrd_pkg::CrcLowPos]  = crc[7:0];
      fr[mrd_pkg::CrcHighPos] = crc[15:8];
      len = mrd_pkg::ReplyLength;
      case (kind)
        FRAME_EXTRA:   len = mrd_pkg::ReplyLength + $urandom_range(1, 4);
        FRAME_SHORT:   len = $urandom_range(mrd_pkg::ReplyLength - 1);
        FRAME_BAD_CRC: begin
          i = $urandom_range(mrd_pkg::ReplyLength - 1);
          fr[i] = fr[i] ^ (8'h01 << $urandom_range(7));
        end
        default: ;
      endcase
      for (i = 0; i < len; i++) begin
        send_item(mrd_pkg::CMD_BYTE,
                  (i < mrd_pkg::ReplyLength) ? fr[i] : 8'($urandom_range(255)));
      end
      send_item(mrd_pkg::CMD_EOF, 8'($urandom_range(255)));
      items_sent += len + 1;
    end
  endtask

  // Mostly well-formed replies, the rest damaged, trimmed or noise.
  task automatic run_phase(input int tx_pct, input int rx_pct);
    int          goal;
    int          pick;
    frame_kind_e kind;
    in_idle_pct  = tx_pct;
    out_idle_pct = rx_pct;
    goal = items_sent + PhaseItems;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 55)      kind = FRAME_GOOD;
      else if (pick < 67) kind = FRAME_EXTRA;
      else if (pick < 79) kind = FRAME_BAD_CRC;
      else if (pick < 91) kind = FRAME_SHORT;
      else                kind = FRAME_NOISE;
      send_frame(kind, 1'b0);
      if ($urandom_range(19) == 0) drain_replies();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty frame, one-byte frame, then a reply with an all-ones payload
    // and trailing bytes, all under the reset alarm code.
    send_item(mrd_pkg::CMD_EOF, 8'h00);
    send_item(mrd_pkg::CMD_BYTE, 8'h00);
    send_item(mrd_pkg::CMD_EOF, 8'hFF);
    send_frame(FRAME_EXTRA, 1'b1);
    drain_replies();

    write_alarm_code(16'h0000);
    run_phase(27, 69);
    drain_replies();
    write_alarm_code(16'hFFFF);
    run_phase(69, 27);
    drain_replies();
    write_alarm_code(16'($urandom_range(65535)));
    run_phase(0, 0);
    drain_replies();

    // Hold the result side off while replies keep coming, so that a closed
    // frame backs up and the input stalls.
    write_alarm_code(mrd_pkg::CommsAlarmReset);
    hold_req++;
    repeat (4) send_frame(FRAME_GOOD, 1'b0);
    drain_replies();

    repeat (10) @(negedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mrd_pkg.sv
sv/mrd_in_stage.sv
sv/mrd_frame_engine.sv
sv/mrd_out_stage.sv
sv/meter_reply_deframer_crc_core.sv
test/meter_reply_checker.sv
test/tb_top.sv
